/* rtl/core/tetg_pkg.sv */
// ----------------------------------------------------------------------------
// tetg_pkg
// Shared widths, types and constants of the tetrahedron geometry block.
// ----------------------------------------------------------------------------
package tetg_pkg;

  localparam int COORD_W    = 32;
  localparam int NUM_COORD  = 12;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int CR_W       = 2 * EDGE_W + 1;
  localparam int PM_W       = CR_W + EDGE_W;
  localparam int DET_W      = PM_W + 1;
  localparam int DEN_W      = DET_W - 1;
  localparam int NUM_W      = 128;
  localparam int QB         = 48;
  localparam int OUT_W      = 48;
  localparam int VOL_W      = 47;
  localparam int MUL_DIG    = 8;
  localparam int MUL_STEPS  = (EDGE_W + MUL_DIG - 1) / MUL_DIG;
  localparam int IN_DATA_W  = NUM_COORD * COORD_W;
  localparam int OUT_DATA_W = ((6 * OUT_W + VOL_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;
  localparam int EVEC_W     = 9 * EDGE_W;
  localparam int Q_DEPTH    = 2;

  localparam int DEF_COORD_FRAC_BITS = 16;
  localparam int DEF_OUT_FRAC_BITS   = 24;

  localparam logic [1:0]       FACE_LAST = 2'd3;
  localparam logic [OUT_W-1:0] SAT_POS   = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [VOL_W-1:0] VOL_MAX   = '1;

  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [CR_W-1:0]   cross_t;
  typedef logic signed [PM_W-1:0]   prod_t;

endpackage

/* rtl/core/tetg_front.sv */
// ----------------------------------------------------------------------------
// tetg_front
// Input side: takes vertex transfers, forms the edge vectors against vertex 3
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tetg_front import tetg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_valid,
  output logic [EVEC_W-1:0]    q_edges,
  input  logic                 q_pop
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [EVEC_W-1:0] edges;
  logic [EVEC_W-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push, pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        edges[(i * 3 + c) * EDGE_W +: EDGE_W] =
          EDGE_W'($signed(in_tdata[(i * 3 + c) * COORD_W +: COORD_W])) -
          EDGE_W'($signed(in_tdata[(9 + c) * COORD_W +: COORD_W]));
      end
    end
  end

  assign in_tready = (count_r != CNT_W'(Q_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_edges   = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= edges;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/tetg_mul.sv */
// ----------------------------------------------------------------------------
// tetg_mul
// Signed multiplier, magnitude times one byte of the short operand per cycle.
// ----------------------------------------------------------------------------
module tetg_mul import tetg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  cross_t a,
  input  edge_t  b,
  output logic   done,
  output prod_t  prod
);

  localparam int STEP_W = $clog2(MUL_STEPS + 1);
  localparam int BM_W   = MUL_STEPS * MUL_DIG;

  logic              busy_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [PM_W-1:0]   am_r, acc_r;
  logic [BM_W-1:0]   bm_r;
  logic [CR_W-1:0]   a_mag;
  logic [EDGE_W-1:0] b_mag;

  assign a_mag = a[CR_W-1] ? CR_W'(-a) : CR_W'(a);
  assign b_mag = b[EDGE_W-1] ? EDGE_W'(-b) : EDGE_W'(b);
  assign done  = done_r;
  assign prod  = neg_r ? $signed(PM_W'(-acc_r)) : $signed(acc_r);

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= PM_W'(a_mag);
      bm_r  <= BM_W'(b_mag);
      acc_r <= '0;
      neg_r <= a[CR_W-1] ^ b[EDGE_W-1];
    end else if (busy_r) begin
      acc_r <= acc_r + PM_W'(am_r * bm_r[MUL_DIG-1:0]);
      am_r  <= am_r << MUL_DIG;
      bm_r  <= bm_r >> MUL_DIG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == STEP_W'(MUL_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/tetg_div.sv */
// ----------------------------------------------------------------------------
// tetg_div
// Unsigned restoring divider, one quotient bit per cycle; flags a quotient
// that does not fit in QB bits.
// ----------------------------------------------------------------------------
module tetg_div import tetg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QB-1:0]    quot,
  output logic             ovf
);

  localparam int HI_W  = NUM_W - QB;
  localparam int CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
  localparam int CNT_W = $clog2(QB);

  logic             busy_r, done_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [QB-1:0]    lo_r, q_r;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             big;

  assign big   = (CMP_W'(num[NUM_W-1:QB]) >= CMP_W'(den));
  assign trial = {rem_r, lo_r[QB-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quot  = q_r;
  assign ovf   = ovf_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:QB]);
      lo_r  <= num[QB-1:0];
      den_r <= den;
      q_r   <= '0;
      ovf_r <= big;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[QB-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= start ? big : (busy_r && (cnt_r == CNT_W'(QB - 1)));
      if (start) begin
        cnt_r  <= '0;
        busy_r <= !big;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QB - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/tetg_back.sv */
// ----------------------------------------------------------------------------
// tetg_back
// Execution side: sequences cross products, determinant, volume, face
// normals and inverse rows over the shared multiplier and divider, and holds
// the result register.
// ----------------------------------------------------------------------------
module tetg_back import tetg_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [EVEC_W-1:0]     q_edges,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam int NS    = OUT_FRAC_BITS - 2 * COORD_FRAC_BITS - 1;
  localparam int NSL   = (NS > 0) ? NS : 0;
  localparam int NSR   = (NS < 0) ? -NS : 0;
  localparam int NW    = CR_W + NSL;
  localparam int VS    = OUT_FRAC_BITS - 3 * COORD_FRAC_BITS;
  localparam int VSL   = (VS > 0) ? VS : 0;
  localparam int VSR   = (VS < 0) ? -VS : 0;
  localparam int SH_W  = NUM_W + VSL + 1;
  localparam int IS    = COORD_FRAC_BITS + OUT_FRAC_BITS;

  // volume divide by six: halve, then byte-serial divide by three
  localparam int VD_STEPS = (VOL_W + 2 + 7) / 8;
  localparam int VD_W     = VD_STEPS * 8;
  localparam int VD_CNT_W = $clog2(VD_STEPS);
  localparam int VL_W     = NUM_W - 1;
  localparam logic [VL_W-1:0] VOL_LIM = VL_W'(3) << VOL_W;
  localparam logic [9:0]      RECIP3  = 10'd683;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CR     = 4'd1;
  localparam logic [3:0] S_CR_W   = 4'd2;
  localparam logic [3:0] S_DET    = 4'd3;
  localparam logic [3:0] S_DET_W  = 4'd4;
  localparam logic [3:0] S_VOL    = 4'd5;
  localparam logic [3:0] S_VOL_W  = 4'd6;
  localparam logic [3:0] S_FACE   = 4'd7;
  localparam logic [3:0] S_FACE_W = 4'd8;
  localparam logic [3:0] S_INV    = 4'd9;
  localparam logic [3:0] S_INV_W  = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  function automatic logic [3:0] cr_idx(input logic [1:0] c, input logic t);
    logic [3:0] r;
    case ({c, t})
      3'b000:  r = {2'd1, 2'd2};
      3'b001:  r = {2'd2, 2'd1};
      3'b010:  r = {2'd2, 2'd0};
      3'b011:  r = {2'd0, 2'd2};
      3'b100:  r = {2'd0, 2'd1};
      3'b101:  r = {2'd1, 2'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [NUM_W-1:0] mag,
                                               input logic neg);
    logic [NUM_W-1:0] lim;
    logic [OUT_W-1:0] v;
    lim = neg ? NUM_W'(SAT_POS) + 1'b1 : NUM_W'(SAT_POS);
    v   = (mag > lim) ? lim[OUT_W-1:0] : mag[OUT_W-1:0];
    return neg ? OUT_W'(-v) : v;
  endfunction

  logic [3:0]       state_r;
  logic [1:0]       j_r, c_r, k_r;
  logic             t_r;
  edge_t            e_r   [3][3];
  cross_t           inv_r [3][3];
  cross_t           n_r   [3];
  logic signed [DET_W-1:0] det_r;
  logic [VOL_W-1:0] vol_r;
  logic [OUT_W-1:0] ir_r  [3];

  logic [VD_W-1:0]     vd_y_r, vd_q_r, vd_q_nxt;
  logic [1:0]          vd_rem_r, vd_rem_nxt;
  logic [VD_CNT_W-1:0] vd_cnt_r;
  logic                vd_big_r, vol_big;
  logic [9:0]          vd_part;
  logic [19:0]         vd_prod;
  logic [7:0]          vd_digit;

  logic             out_valid_r, out_last_r, out_deg_r;
  logic [1:0]       out_face_r;
  logic [OUT_W-1:0] out_n_r [3];
  logic [OUT_W-1:0] out_i_r [3];
  logic [VOL_W-1:0] out_vol_r;

  logic [1:0]       ja, jb, i1, i2, k1, k2;
  edge_t            fa [3];
  edge_t            fb [3];
  edge_t            ek, ek1, ek2;
  cross_t           mul_a;
  edge_t            mul_b;
  logic             mul_start, mul_done;
  prod_t            mul_prod;
  logic             div_start, div_done, div_ovf;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [QB-1:0]    div_q;
  logic             dzero, fzero, det_neg, emit_go;
  logic [DEN_W-1:0] dmag;
  logic [SH_W-1:0]  vsh;
  logic [NUM_W-1:0] vol_num, inv_num;
  logic [CR_W-1:0]  imag, nmag;
  logic [NW-1:0]    nsh;
  logic [OUT_W-1:0] nrm_out [3];

  assign {i1, i2} = cr_idx(c_r, t_r);
  assign ja       = (j_r == 2'd0) ? 2'd1 : (j_r == 2'd1) ? 2'd2 : 2'd0;
  assign jb       = (j_r == 2'd0) ? 2'd2 : (j_r == 2'd1) ? 2'd0 : 2'd1;
  assign k1       = k_r + 2'd1;
  assign k2       = k_r + 2'd2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ek  = (k_r == FACE_LAST) ? '0 : e_r[k_r][c];
      ek1 = (k1 == FACE_LAST) ? '0 : e_r[k1][c];
      ek2 = (k2 == FACE_LAST) ? '0 : e_r[k2][c];
      fa[c] = ek1 - ek;
      fb[c] = ek2 - ek;
    end
  end

  assign det_neg = det_r[DET_W-1];
  assign dzero   = (det_r == '0);
  assign dmag    = det_neg ? DEN_W'(-det_r) : DEN_W'(det_r);
  assign fzero   = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

  assign vsh     = (SH_W'(dmag) << VSL) >> VSR;
  assign vol_num = (|vsh[SH_W-1:NUM_W]) ? '1 : vsh[NUM_W-1:0];
  assign imag    = inv_r[k_r][c_r][CR_W-1] ? CR_W'(-inv_r[k_r][c_r])
                                            : CR_W'(inv_r[k_r][c_r]);
  assign inv_num = NUM_W'(imag) << IS;

  assign vol_big    = (vol_num[NUM_W-1:1] >= VOL_LIM);
  assign vd_part    = {vd_rem_r, vd_y_r[VD_W-1 -: 8]};
  assign vd_prod    = 20'(vd_part) * 20'(RECIP3);
  assign vd_digit   = vd_prod[18:11];
  assign vd_rem_nxt = 2'(vd_part - ({1'b0, vd_digit, 1'b0} + {2'b00, vd_digit}));
  assign vd_q_nxt   = {vd_q_r[VD_W-9:0], vd_digit};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nmag       = n_r[c][CR_W-1] ? CR_W'(-n_r[c]) : CR_W'(n_r[c]);
      nsh        = (NW'(nmag) << NSL) >> NSR;
      nrm_out[c] = sat_out(NUM_W'(nsh), n_r[c][CR_W-1] ^ ~k_r[0]);
    end
  end

  always_comb begin
    case (state_r)
      S_DET: begin
        mul_a = inv_r[0][c_r];
        mul_b = e_r[0][c_r];
      end
      S_FACE: begin
        mul_a = CR_W'(fa[i1]);
        mul_b = fb[i2];
      end
      default: begin
        mul_a = CR_W'(e_r[ja][i1]);
        mul_b = e_r[jb][i2];
      end
    endcase
  end

  assign mul_start = (state_r == S_CR) || (state_r == S_DET) || (state_r == S_FACE);
  assign div_start = (state_r == S_INV);
  assign div_num   = inv_num;
  assign div_den   = dmag;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  tetg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tetg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q),
    .ovf   (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          e_r[i][c] <= $signed(q_edges[(i * 3 + c) * EDGE_W +: EDGE_W]);
        end
      end
    end
    if ((state_r == S_CR_W) && mul_done) begin
      inv_r[j_r][c_r] <= t_r ? inv_r[j_r][c_r] - CR_W'(mul_prod) : CR_W'(mul_prod);
    end
    if ((state_r == S_DET_W) && mul_done) begin
      det_r <= (c_r == 2'd0) ? DET_W'(mul_prod) : det_r + DET_W'(mul_prod);
    end
    if (state_r == S_VOL) begin
      vd_y_r   <= vol_num[VD_W:1];
      vd_q_r   <= '0;
      vd_rem_r <= '0;
      vd_cnt_r <= '0;
      vd_big_r <= vol_big;
    end else if (state_r == S_VOL_W) begin
      vd_y_r   <= vd_y_r << 8;
      vd_q_r   <= vd_q_nxt;
      vd_rem_r <= vd_rem_nxt;
      vd_cnt_r <= vd_cnt_r + 1'b1;
      if (vd_cnt_r == VD_CNT_W'(VD_STEPS - 1)) begin
        vol_r <= vd_big_r ? VOL_MAX : vd_q_nxt[VOL_W-1:0];
      end
    end
    if ((state_r == S_FACE_W) && mul_done) begin
      n_r[c_r] <= t_r ? n_r[c_r] - CR_W'(mul_prod) : CR_W'(mul_prod);
    end
    if ((state_r == S_INV_W) && div_done) begin
      ir_r[c_r] <= sat_out(div_ovf ? '1 : NUM_W'(div_q),
                           inv_r[k_r][c_r][CR_W-1] ^ det_neg);
    end
    if (emit_go) begin
      out_face_r <= k_r;
      out_last_r <= (k_r == FACE_LAST);
      out_deg_r  <= dzero || fzero;
      out_vol_r  <= vol_r;
      for (int c = 0; c < 3; c++) begin
        out_n_r[c] <= nrm_out[c];
        out_i_r[c] <= ((k_r == FACE_LAST) || dzero) ? '0 : ir_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      c_r         <= '0;
      t_r         <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_go || (out_valid_r && !out_tready);
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            j_r     <= '0;
            c_r     <= '0;
            t_r     <= 1'b0;
            state_r <= S_CR;
          end
        end
        S_CR:   state_r <= S_CR_W;
        S_CR_W: begin
          if (mul_done) begin
            t_r <= !t_r;
            if (t_r && (c_r == 2'd2) && (j_r == 2'd2)) begin
              state_r <= S_DET;
            end else begin
              state_r <= S_CR;
            end
            if (t_r) begin
              if (c_r == 2'd2) begin
                c_r <= '0;
                j_r <= (j_r == 2'd2) ? 2'd0 : j_r + 2'd1;
              end else begin
                c_r <= c_r + 2'd1;
              end
            end
          end
        end
        S_DET:   state_r <= S_DET_W;
        S_DET_W: begin
          if (mul_done) begin
            if (c_r == 2'd2) begin
              c_r     <= '0;
              state_r <= S_VOL;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_DET;
            end
          end
        end
        S_VOL:   state_r <= S_VOL_W;
        S_VOL_W: begin
          if (vd_cnt_r == VD_CNT_W'(VD_STEPS - 1)) begin
            k_r     <= '0;
            state_r <= S_FACE;
          end
        end
        S_FACE:   state_r <= S_FACE_W;
        S_FACE_W: begin
          if (mul_done) begin
            t_r <= !t_r;
            if (t_r && (c_r == 2'd2)) begin
              c_r     <= '0;
              state_r <= ((k_r != FACE_LAST) && !dzero) ? S_INV : S_EMIT;
            end else begin
              state_r <= S_FACE;
              if (t_r) begin
                c_r <= c_r + 2'd1;
              end
            end
          end
        end
        S_INV:   state_r <= S_INV_W;
        S_INV_W: begin
          if (div_done) begin
            if (c_r == 2'd2) begin
              c_r     <= '0;
              state_r <= S_EMIT;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_INV;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (k_r == FACE_LAST) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_FACE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_deg_r, out_face_r};
  assign out_tdata  = OUT_DATA_W'({out_vol_r, out_i_r[2], out_i_r[1], out_i_r[0],
                                   out_n_r[2], out_n_r[1], out_n_r[0]});

endmodule

/* rtl/core/tet_element_geometry.sv */
// ----------------------------------------------------------------------------
// tet_element_geometry
// Linear tetrahedron precompute: face normals, inverse edge matrix rows and
// volume, four results per tetrahedron.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: p0_x..p3_z, 32 bits each
//  out_    | out | out_tvalid/tready  | tdata: normals, inverse row, volume;
//          |     |                    | tuser: face, degenerate; tlast
//
//  Per tetrahedron: 45 products on one serial multiplier, nine divisions on
//  one bit-per-cycle divider and a byte-serial divide by six; the divisions
//  are skipped when the determinant is zero.
//  A two-entry queue takes new tetrahedra while the back end works; the
//  result register holds under out_tready low and only that stalls the back.
//  Synchronous active-low reset clears the queue, sequencer and valid flag.
// ----------------------------------------------------------------------------
module tet_element_geometry import tetg_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // p0_x p0_y p0_z p1_x .. p3_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // normal_x/y/z inv_row_x/y/z tet_volume
  output logic [OUT_USER_W-1:0] out_tuser,  // face_index degenerate
  output logic                  out_tlast
);

  logic              q_valid, q_pop;
  logic [EVEC_W-1:0] q_edges;

  tetg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_edges   (q_edges),
    .q_pop     (q_pop)
  );

  tetg_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_edges    (q_edges),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/tetg_checker.sv */
// ----------------------------------------------------------------------------
// tetg_checker
// Port-level checks on the result stream of tet_element_geometry.
// ----------------------------------------------------------------------------
module tetg_checker import tetg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  localparam int INV_LO = 3 * OUT_W;
  localparam int INV_HI = 6 * OUT_W - 1;

  logic [1:0] face_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_exp_r <= '0;
    end else if (out_tvalid && out_tready) begin
      face_exp_r <= face_exp_r + 2'd1;
    end
  end

  a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] == face_exp_r)
    else $error("face index out of sequence");

  a_last_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[1:0] == FACE_LAST)))
    else $error("tlast does not match last face");

  a_last_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[INV_HI:INV_LO] == '0)
    else $error("inverse row not zero on last face");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind tet_element_geometry tetg_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
